@@ hdl/u8dec_pkg.sv @@
// Package for the UTF-8 code point decoder.
// Holds the byte class table, the automaton transitions and the status codes.
// No dependencies.
package u8dec_pkg;

    localparam int unsigned CP_W     = 21;
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned STATE_W  = 4;
    localparam int unsigned CLASS_W  = 4;

    localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
    localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;
    localparam logic [STATE_W-1:0] ST_LAST   = 4'd8;

    localparam logic [STATUS_W-1:0] STATUS_VALID     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic [CP_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

    typedef logic [CP_W-1:0]     code_point_t;
    typedef logic [LEN_W-1:0]    byte_len_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [STATE_W-1:0]  dfa_state_t;
    typedef logic [CLASS_W-1:0]  byte_class_t;

    function automatic byte_class_t byte_class(input logic [7:0] b);
        byte_class_t c;
        c = 4'd8;
        priority if (b < 8'h80) begin
            c = 4'd0;
        end else if (b < 8'h90) begin
            c = 4'd1;
        end else if (b < 8'hA0) begin
            c = 4'd9;
        end else if (b < 8'hC0) begin
            c = 4'd7;
        end else if (b < 8'hC2) begin
            c = 4'd8;
        end else if (b < 8'hE0) begin
            c = 4'd2;
        end else if (b == 8'hE0) begin
            c = 4'd10;
        end else if (b == 8'hED) begin
            c = 4'd4;
        end else if (b < 8'hF0) begin
            c = 4'd3;
        end else if (b == 8'hF0) begin
            c = 4'd11;
        end else if (b < 8'hF4) begin
            c = 4'd6;
        end else if (b == 8'hF4) begin
            c = 4'd5;
        end else begin
            c = 4'd8;
        end
        return c;
    endfunction

    // Rows above the last state behave as the reject row.
    function automatic dfa_state_t dfa_next(input dfa_state_t st, input byte_class_t c);
        dfa_state_t n;
        n = ST_REJECT;
        unique case (st)
            4'd0: begin
                unique case (c)
                    4'd0:    n = 4'd0;
                    4'd2:    n = 4'd2;
                    4'd3:    n = 4'd3;
                    4'd4:    n = 4'd5;
                    4'd5:    n = 4'd8;
                    4'd6:    n = 4'd7;
                    4'd10:   n = 4'd4;
                    4'd11:   n = 4'd6;
                    default: n = ST_REJECT;
                endcase
            end
            4'd2: n = (c == 4'd1 || c == 4'd7 || c == 4'd9) ? 4'd0 : ST_REJECT;
            4'd3: n = (c == 4'd1 || c == 4'd7 || c == 4'd9) ? 4'd2 : ST_REJECT;
            4'd4: n = (c == 4'd7) ? 4'd2 : ST_REJECT;
            4'd5: n = (c == 4'd1 || c == 4'd9) ? 4'd2 : ST_REJECT;
            4'd6: n = (c == 4'd7 || c == 4'd9) ? 4'd3 : ST_REJECT;
            4'd7: n = (c == 4'd1 || c == 4'd7 || c == 4'd9) ? 4'd3 : ST_REJECT;
            4'd8: n = (c == 4'd1) ? 4'd3 : ST_REJECT;
            default: n = ST_REJECT;
        endcase
        return n;
    endfunction

endpackage

@@ hdl/utf8_codepoint_decoder_core.sv @@
// UTF-8 code point decoder, top level.
// Byte classing, automaton step and value accumulation ahead of one result register.
// Depends on u8dec_pkg.
//
// Takes one byte per clock and gives at most one code point per byte. A result
// appears on the master side in the cycle after the transfer of the byte that
// completes, rejects or truncates its sequence, driven from the single result
// register. The slave side stays ready while the result register is empty or
// being drained, so bytes flow at one per cycle under no backpressure. Invalid
// sequences give U+FFFD counting the offending byte; a buffer ending
// mid-sequence gives the partial value marked truncated.
module utf8_codepoint_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] byte_length
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import u8dec_pkg::*;

    dfa_state_t  state_reg, state_next;
    code_point_t partial_reg, partial_next;
    byte_len_t   taken_reg, taken_next;

    logic        out_valid_reg, out_valid_next;
    code_point_t out_cp_reg, out_cp_next;
    byte_len_t   out_len_reg, out_len_next;
    status_t     out_status_reg, out_status_next;

    logic        in_xfer;
    byte_class_t cls;
    dfa_state_t  step;
    code_point_t value;
    byte_len_t   taken_inc;
    logic [7:0]  lead_mask;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign cls       = byte_class(s_axis_tdata);
    assign step      = dfa_next(state_reg, cls);
    assign taken_inc = taken_reg + 3'd1;
    assign lead_mask = (cls > 4'd7) ? 8'h00 : (8'hFF >> cls[2:0]);

    always_comb begin
        if (state_reg != ST_ACCEPT) begin
            value = {partial_reg[CP_W-7:0], s_axis_tdata[5:0]};
        end else begin
            value = {13'd0, lead_mask & s_axis_tdata};
        end
    end

    always_comb begin
        state_next      = state_reg;
        partial_next    = partial_reg;
        taken_next      = taken_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_cp_next     = out_cp_reg;
        out_len_next    = out_len_reg;
        out_status_next = out_status_reg;
        if (in_xfer) begin
            priority if (step == ST_ACCEPT || step == ST_REJECT || s_axis_tlast) begin
                out_valid_next  = 1'b1;
                out_len_next    = taken_inc;
                out_cp_next     = (step == ST_REJECT) ? REPLACEMENT_CHAR : value;
                out_status_next = (step == ST_ACCEPT) ? STATUS_VALID :
                                  (step == ST_REJECT) ? STATUS_INVALID : STATUS_TRUNCATED;
                state_next      = ST_ACCEPT;
                partial_next    = '0;
                taken_next      = '0;
            end else begin
                state_next   = step;
                partial_next = value;
                taken_next   = taken_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCEPT;
            partial_reg   <= '0;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            partial_reg   <= partial_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_cp_reg     <= out_cp_next;
        out_len_reg    <= out_len_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_len_reg, out_cp_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

@@ verif/utf8_codepoint_decoder_core_test.sv @@
// Self-checking testbench for utf8_codepoint_decoder_core: directed byte table, then random well-formed,
// broken and truncated sequences, first under random stalls on both streams and then with none.
// Depends on u8dec_pkg and the decoder RTL.
module utf8_codepoint_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import u8dec_pkg::*;

    typedef struct packed {
        code_point_t cp;
        byte_len_t   len;
        status_t     st;
    } decoded_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       pinned;
        decoded_t   want;
    } row_t;

    localparam decoded_t NO_PIN = '0;

    localparam byte_class_t CL_ASCII   = 4'd0;
    localparam byte_class_t CL_CONT_80 = 4'd1;
    localparam byte_class_t CL_LEAD2   = 4'd2;
    localparam byte_class_t CL_LEAD3   = 4'd3;
    localparam byte_class_t CL_ED      = 4'd4;
    localparam byte_class_t CL_F4      = 4'd5;
    localparam byte_class_t CL_LEAD4   = 4'd6;
    localparam byte_class_t CL_CONT_A0 = 4'd7;
    localparam byte_class_t CL_BAD     = 4'd8;
    localparam byte_class_t CL_CONT_90 = 4'd9;
    localparam byte_class_t CL_E0      = 4'd10;
    localparam byte_class_t CL_F0      = 4'd11;

    // next state per row, nibble n is the entry for byte class n
    localparam logic [8:0][63:0] NEXT_TAB = {
        64'h1111_1111_1111_1131,
        64'h1111_1131_3111_1131,
        64'h1111_1131_3111_1111,
        64'h1111_1121_1111_1121,
        64'h1111_1111_2111_1111,
        64'h1111_1121_2111_1121,
        64'h1111_1101_0111_1101,
        64'h1111_1111_1111_1111,
        64'h1111_6411_1785_3210
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    dfa_state_t  dec_state = ST_ACCEPT;
    code_point_t dec_partial = '0;
    byte_len_t   dec_taken = '0;

    decoded_t    expected_points [$];
    row_t        script_rows [$];
    int          error_count = 0;
    int          sender_idle_pct = 36;
    int          sink_idle_pct = 50;

    utf8_codepoint_decoder_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic byte_class_t classify(input logic [7:0] b);
        if (!b[7]) begin
            return CL_ASCII;
        end
        case (b[7:4])
            4'h8: return CL_CONT_80;
            4'h9: return CL_CONT_90;
            4'hA, 4'hB: return CL_CONT_A0;
            4'hC, 4'hD: return (b < 8'hC2) ? CL_BAD : CL_LEAD2;
            4'hE: begin
                if (b == 8'hE0) return CL_E0;
                if (b == 8'hED) return CL_ED;
                return CL_LEAD3;
            end
            default: begin
                if (b == 8'hF0) return CL_F0;
                if (b < 8'hF4) return CL_LEAD4;
                if (b == 8'hF4) return CL_F4;
                return CL_BAD;
            end
        endcase
    endfunction

    // advances the decode state by one byte; returns 1 when a code point is due
    function automatic bit decode_step(input logic [7:0] b, input logic last,
                                       output decoded_t res);
        byte_class_t cls;
        dfa_state_t  row;
        dfa_state_t  nxt;
        code_point_t val;
        cls = classify(b);
        row = (dec_state > ST_LAST) ? ST_REJECT : dec_state;
        if (dec_state != ST_ACCEPT) begin
            val = {dec_partial[14:0], b[5:0]};
        end else begin
            val = {13'd0, (8'hFF >> cls) & b};
        end
        nxt = NEXT_TAB[row][cls*4 +: 4];
        dec_taken = dec_taken + 3'd1;
        res.len = dec_taken;
        res.cp = val;
        if (nxt == ST_ACCEPT) begin
            res.st = STATUS_VALID;
        end else if (nxt == ST_REJECT) begin
            res.st = STATUS_INVALID;
            res.cp = REPLACEMENT_CHAR;
        end else if (last) begin
            res.st = STATUS_TRUNCATED;
        end else begin
            dec_state = nxt;
            dec_partial = val;
            return 1'b0;
        end
        dec_state = ST_ACCEPT;
        dec_partial = '0;
        dec_taken = '0;
        return 1'b1;
    endfunction

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last, input logic pinned,
                             input decoded_t want);
        decoded_t got;
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        if (decode_step(b, last, got) && !pinned) begin
            expected_points.push_back(got);
        end
        if (pinned) begin
            expected_points.push_back(want);
        end
        @(negedge aclk);
    endtask

    // one encoded code point, possibly corrupted or cut short, or a single noise byte
    task automatic random_sequence(output int n_sent);
        int          kind;
        int          n;
        int          cut;
        int          lo;
        int          hi;
        int          pick;
        logic        eob;
        logic [20:0] cp;
        logic [7:0]  seq [4];
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0, NO_PIN);
            n_sent = 1;
        end else begin
            n = $urandom_range(1, 4);
            case (n)
                1: begin lo = 'h0;     hi = 'h7F;     end
                2: begin lo = 'h80;    hi = 'h7FF;    end
                3: begin lo = 'h800;   hi = 'hFFFF;   end
                default: begin lo = 'h10000; hi = 'h10FFFF; end
            endcase
            pick = $urandom_range(0, 7);
            cp = 21'((pick == 0) ? lo : (pick == 1) ? hi : $urandom_range(lo, hi));
            case (n)
                1: seq[0] = cp[7:0];
                2: begin
                    seq[0] = {3'b110, cp[10:6]};
                    seq[1] = {2'b10, cp[5:0]};
                end
                3: begin
                    seq[0] = {4'b1110, cp[15:12]};
                    seq[1] = {2'b10, cp[11:6]};
                    seq[2] = {2'b10, cp[5:0]};
                end
                default: begin
                    seq[0] = {5'b11110, cp[20:18]};
                    seq[1] = {2'b10, cp[17:12]};
                    seq[2] = {2'b10, cp[11:6]};
                    seq[3] = {2'b10, cp[5:0]};
                end
            endcase
            if (kind < 30 && n > 1) begin
                seq[$urandom_range(1, n - 1)] = 8'($urandom_range(0, 255));
            end
            if (kind >= 30 && kind < 40 && n > 1) begin
                cut = $urandom_range(1, n - 1);
                eob = 1'b1;
            end else begin
                cut = n;
                eob = ($urandom_range(0, 5) == 0);
            end
            for (int i = 0; i < cut; i++) begin
                send_byte(seq[i], eob && (i == cut - 1), 1'b0, NO_PIN);
            end
            n_sent = cut;
        end
    endtask

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin : check_results
        decoded_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected transfer: code_point %h byte_length %0d status %0d",
                       m_axis_tdata[20:0], m_axis_tdata[23:21], m_axis_tuser);
                error_count++;
            end else begin
                want = expected_points.pop_front();
                if (m_axis_tdata[20:0] !== want.cp) begin
                    $error("code_point: expected %h, got %h", want.cp, m_axis_tdata[20:0]);
                    error_count++;
                end
                if (m_axis_tdata[23:21] !== want.len) begin
                    $error("byte_length: expected %0d, got %0d", want.len,
                           m_axis_tdata[23:21]);
                    error_count++;
                end
                if (m_axis_tuser !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("utf8_codepoint_decoder_core test failed");
        $finish;
    end

    initial begin
        int sent;
        int n;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // byte, end of buffer, pinned, expected code point / length / status
        script_rows.push_back({8'h00, 1'b0, 1'b1, 21'h000000, 3'd1, STATUS_VALID});
        script_rows.push_back({8'h7F, 1'b0, 1'b1, 21'h00007F, 3'd1, STATUS_VALID});
        script_rows.push_back({8'hFF, 1'b0, 1'b1, REPLACEMENT_CHAR, 3'd1, STATUS_INVALID});
        script_rows.push_back({8'h80, 1'b0, 1'b1, REPLACEMENT_CHAR, 3'd1, STATUS_INVALID});
        script_rows.push_back({8'hC0, 1'b0, 1'b1, REPLACEMENT_CHAR, 3'd1, STATUS_INVALID});
        script_rows.push_back({8'hC3, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'hA9, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'hE2, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'h82, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'hAC, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'hF0, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'h9F, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'h98, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'h80, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'hF4, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'h8F, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'hBF, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'hBF, 1'b1, 1'b1, 21'h10FFFF, 3'd4, STATUS_VALID});
        // reject on the final byte beats truncation
        script_rows.push_back({8'hE0, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'h80, 1'b1, 1'b1, REPLACEMENT_CHAR, 3'd2, STATUS_INVALID});
        // surrogate lead-in
        script_rows.push_back({8'hED, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'hA0, 1'b0, 1'b1, REPLACEMENT_CHAR, 3'd2, STATUS_INVALID});
        script_rows.push_back({8'hF0, 1'b0, 1'b0, NO_PIN});
        script_rows.push_back({8'h9F, 1'b1, 1'b0, NO_PIN});
        script_rows.push_back({8'hC3, 1'b1, 1'b1, 21'h000003, 3'd1, STATUS_TRUNCATED});

        foreach (script_rows[i]) begin
            send_byte(script_rows[i].b, script_rows[i].last, script_rows[i].pinned,
                      script_rows[i].want);
        end

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 50 : 0;
            sink_idle_pct   = (phase == 0) ? 50 : (phase == 1) ? 36 : 0;
            sent = 0;
            while (sent < 180) begin
                random_sequence(n);
                sent += n;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (expected_points.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("utf8_codepoint_decoder_core test passed");
        end else begin
            $display("utf8_codepoint_decoder_core test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/u8dec_pkg.sv
hdl/utf8_codepoint_decoder_core.sv
verif/utf8_codepoint_decoder_core_test.sv
